FILE: hdl/dive_log_record_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Dive log record decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef DIVE_LOG_RECORD_DECODER_TOP_MACROS_SVH
`define DIVE_LOG_RECORD_DECODER_TOP_MACROS_SVH

// checked only out of reset
`define DLRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DLRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/dlrd_pkg.sv
// ----------------------------------------------------------------------------
// Dive log record decoder package
// Shared constants, result codes, types and the sample gather map.
// ----------------------------------------------------------------------------
package dlrd_pkg;

    localparam int GAS_ENTRIES_DEF  = 8;
    localparam int TANK_ENTRIES_DEF = 10;
    localparam int RECORD_BYTES_DEF = 64;

    localparam int BUF_AW  = 6;
    localparam int NGATHER = 38;

    localparam logic [6:0] MIN_REC  = 7'h2A;
    localparam logic [6:0] LONG_REC = 7'h40;

    localparam logic [1:0] CFG_HAS_TYPE  = 2'd0;
    localparam logic [1:0] CFG_HDR_SIZE  = 2'd1;
    localparam logic [1:0] CFG_REC_SIZE  = 2'd2;
    localparam logic [1:0] CFG_DECO_TIME = 2'd3;

    localparam logic [7:0] HDR_SIZE_RST = 8'd50;
    localparam logic [6:0] REC_SIZE_RST = 7'd42;

    localparam logic [4:0] K_TIME     = 5'd0;
    localparam logic [4:0] K_DEPTH    = 5'd1;
    localparam logic [4:0] K_TEMP     = 5'd2;
    localparam logic [4:0] K_SETPOINT = 5'd3;
    localparam logic [4:0] K_GAS      = 5'd4;
    localparam logic [4:0] K_DECO     = 5'd5;
    localparam logic [4:0] K_NDL      = 5'd6;
    localparam logic [4:0] K_CNS      = 5'd7;
    localparam logic [4:0] K_PRESSURE = 5'd8;
    localparam logic [4:0] K_LINKLOST = 5'd9;
    localparam logic [4:0] K_BEARING  = 5'd10;
    localparam logic [4:0] K_ERROR    = 5'd11;
    localparam logic [4:0] K_TOTALS   = 5'd12;
    localparam logic [4:0] K_SETTINGS = 5'd13;
    localparam logic [4:0] K_GASENT   = 5'd14;
    localparam logic [4:0] K_TANKENT  = 5'd15;
    localparam logic [4:0] K_LOCATION = 5'd16;

    localparam logic [3:0] E_TIME_BACK = 4'd1;
    localparam logic [3:0] E_GAS_FULL  = 4'd2;
    localparam logic [3:0] E_TANK_FULL = 4'd3;

    localparam logic [7:0] MODE_SCR = 8'd1;
    localparam logic [7:0] MODE_CCR = 8'd2;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  index;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic        last;
    } t_res;

    // record byte address of gather slot k
    function automatic logic [BUF_AW-1:0] gaddr(input logic [5:0] k);
        logic [5:0] a;
        if (k <= 6'd9)       a = k + 6'd2;
        else if (k <= 6'd12) a = k + 6'd4;
        else if (k <= 6'd21) a = k + 6'd5;
        else if (k <= 6'd23) a = k + 6'd7;
        else                 a = k + 6'd16;
        return a;
    endfunction

    // gather slot of record byte address a
    function automatic logic [5:0] gidx(input logic [5:0] a);
        logic [5:0] k;
        if (a <= 6'd11)      k = a - 6'd2;
        else if (a <= 6'd16) k = a - 6'd4;
        else if (a <= 6'd26) k = a - 6'd5;
        else if (a <= 6'd30) k = a - 6'd7;
        else                 k = a - 6'd16;
        return k;
    endfunction

endpackage

FILE: hdl/dlrd_rec_buf.sv
// ----------------------------------------------------------------------------
// Record buffer
// Single-port-write, single-read record byte memory, registered read data.
// ----------------------------------------------------------------------------
module dlrd_rec_buf #(
    parameter int RECORD_BYTES = dlrd_pkg::RECORD_BYTES_DEF
) (
    input  logic                      i_clk,
    input  dlrd_pkg::t_buf_wr         i_wr,
    input  logic [dlrd_pkg::BUF_AW-1:0] i_raddr,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [RECORD_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/dlrd_core.sv
// ----------------------------------------------------------------------------
// Record decoder core
// Byte framing, record gather, sample/info decode, tables and summary run.
// ----------------------------------------------------------------------------
`include "dive_log_record_decoder_top_macros.svh"

module dlrd_core #(
    parameter int GAS_ENTRIES  = dlrd_pkg::GAS_ENTRIES_DEF,
    parameter int TANK_ENTRIES = dlrd_pkg::TANK_ENTRIES_DEF,
    parameter int RECORD_BYTES = dlrd_pkg::RECORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_has_record_type,
    input  logic [7:0]                  i_header_size,
    input  logic [6:0]                  i_record_size,
    input  logic                        i_deco_time_present,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first_of_dive,
    input  logic                        i_last_of_dive,
    output dlrd_pkg::t_buf_wr           o_buf_wr,
    output logic [dlrd_pkg::BUF_AW-1:0] o_buf_raddr,
    input  logic [7:0]                  i_buf_rdata,
    output logic                        o_valid,
    input  logic                        i_stall,
    output dlrd_pkg::t_res              o_res
);

    localparam int GCW = $clog2(GAS_ENTRIES + 1);
    localparam int GIW = (GAS_ENTRIES > 1) ? $clog2(GAS_ENTRIES) : 1;
    localparam int TCW = $clog2(TANK_ENTRIES + 1);
    localparam int TIW = (TANK_ENTRIES > 1) ? $clog2(TANK_ENTRIES) : 1;
    localparam int SW  = (GCW > TCW) ? GCW : TCW;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GATHER, ST_GWAIT, ST_TYPE, ST_TIME, ST_DEPTH, ST_TEMP,
        ST_SET, ST_GSRCH, ST_DECO, ST_CNS, ST_TANK, ST_TSRCH, ST_TADD,
        ST_TPR, ST_BEAR, ST_FIN, ST_STOT, ST_SSET, ST_SGAS, ST_STANK,
        ST_SLOC, ST_FLUSH
    } t_state;

    t_state r_st;

    logic [7:0]     r_hl;
    logic [6:0]     r_pos;
    logic           r_last;
    logic [5:0]     r_k;
    logic           r_rv;
    logic [5:0]     r_rk;
    logic           r_rz;
    logic [7:0]     r_g [dlrd_pkg::NGATHER];
    logic [31:0]    r_lt;
    logic [15:0]    r_maxd;
    logic           r_prev_v;
    logic [15:0]    r_prev;
    logic [15:0]    r_gas [GAS_ENTRIES];
    logic [GCW-1:0] r_gcnt;
    logic [21:0]    r_tank [TANK_ENTRIES];
    logic [TCW-1:0] r_tcnt;
    logic           r_cur_v;
    logic [3:0]     r_cur_id;
    logic [TCW-1:0] r_cur_ix;
    logic           r_set_v;
    logic [31:0]    r_set;
    logic           r_err;
    logic           r_bear;
    logic           r_loc;
    logic [31:0]    r_loc_w [3];
    logic [SW-1:0]  r_si;
    logic           r_pend_v;
    dlrd_pkg::t_res r_pend;
    logic           r_out_v;
    dlrd_pkg::t_res r_out;

    logic [6:0]  w_size;
    logic        w_acc;
    logic        w_err0;
    logic [7:0]  w_hl0;
    logic [6:0]  w_pos0;
    logic [6:0]  w_npos;
    logic        w_out_free;
    logic        w_ok;
    logic        w_push;
    logic        e_v;
    dlrd_pkg::t_res e_res;

    logic [31:0] w_ts;
    logic [15:0] w_depth;
    logic [15:0] w_temp;
    logic [7:0]  w_mode;
    logic [15:0] w_sp;
    logic [15:0] w_gasv;
    logic [15:0] w_stop;
    logic [15:0] w_dtime;
    logic [15:0] w_tts;
    logic [15:0] w_cns;
    logic [7:0]  w_b47;
    logic [3:0]  w_id;
    logic [8:0]  w_pr;
    logic [15:0] w_brg;
    logic [15:0] w_type;
    logic        w_terr;
    logic        w_long;
    logic        w_gmatch;
    logic        w_tmatch;
    logic        w_tnew;
    logic        w_bemit;

    function automatic logic [7:0] gb(input logic [5:0] a);
        return r_g[dlrd_pkg::gidx(a)];
    endfunction

    assign w_size = (i_record_size < dlrd_pkg::MIN_REC) ? dlrd_pkg::MIN_REC :
                    (i_record_size > 7'(RECORD_BYTES)) ? 7'(RECORD_BYTES) : i_record_size;

    assign w_acc  = i_valid && !o_stall;
    assign w_err0 = i_first_of_dive ? 1'b0 : r_err;
    assign w_hl0  = i_first_of_dive ? i_header_size : r_hl;
    assign w_pos0 = i_first_of_dive ? 7'd0 : r_pos;
    assign w_npos = w_pos0 + 7'd1;

    assign o_stall = (r_st != ST_IDLE);

    assign o_buf_wr.we   = w_acc && !w_err0 && (w_hl0 == 8'd0) && (w_pos0 < 7'(RECORD_BYTES));
    assign o_buf_wr.addr = w_pos0[dlrd_pkg::BUF_AW-1:0];
    assign o_buf_wr.data = i_data_byte;
    assign o_buf_raddr   = dlrd_pkg::gaddr(r_k);

    assign w_ts    = {gb(6'd5), gb(6'd4), gb(6'd3), gb(6'd2)};
    assign w_depth = {gb(6'd7), gb(6'd6)};
    assign w_temp  = {gb(6'd9), gb(6'd8)};
    assign w_mode  = gb(6'd18);
    assign w_sp    = {gb(6'd20), gb(6'd19)};
    assign w_gasv  = {gb(6'd10), gb(6'd11)};
    assign w_stop  = {gb(6'd22), gb(6'd21)};
    assign w_dtime = i_deco_time_present ? {gb(6'd24), gb(6'd23)} : 16'd0;
    assign w_tts   = i_deco_time_present ? {gb(6'd26), gb(6'd25)} : {gb(6'd24), gb(6'd23)};
    assign w_cns   = {gb(6'd30), gb(6'd29)};
    assign w_b47   = gb(6'd47);
    assign w_id    = w_b47[3:0];
    assign w_pr    = w_b47[5] ? {gb(6'd49), 1'b0} : {1'b0, gb(6'd49)};
    assign w_brg   = {gb(6'd51), gb(6'd50)};
    assign w_type  = i_has_record_type ? {gb(6'd53), gb(6'd52)} : 16'd0;
    assign w_terr  = (r_lt != 32'd0) && (w_ts <= r_lt);
    assign w_long  = (w_size >= dlrd_pkg::LONG_REC);
    assign w_gmatch = (r_gas[r_si[GIW-1:0]] == w_gasv);
    assign w_tmatch = (r_tank[r_si[TIW-1:0]][21:18] == w_id);
    assign w_tnew   = ({{(SW-TCW){1'b0}}, r_cur_ix} >= SW'(r_tcnt)) && (w_pr != 9'd0);
    assign w_bemit  = (r_bear || (w_brg != 16'd0)) && (w_brg != 16'hFFFF);

    assign w_out_free = !r_out_v || !i_stall;
    assign w_ok       = !r_pend_v || w_out_free;
    assign w_push     = r_pend_v && w_out_free && (e_v || (r_st == ST_FLUSH));

    always_comb begin
        e_v   = 1'b0;
        e_res = '0;
        unique case (r_st)
            ST_TIME: begin
                e_v = w_ok;
                e_res.value_a = w_ts;
                if (w_terr) begin
                    e_res.kind    = dlrd_pkg::K_ERROR;
                    e_res.index   = dlrd_pkg::E_TIME_BACK;
                    e_res.value_b = r_lt;
                end else begin
                    e_res.kind = dlrd_pkg::K_TIME;
                end
            end
            ST_DEPTH: begin
                e_v = w_ok;
                e_res.kind    = dlrd_pkg::K_DEPTH;
                e_res.value_a = {16'd0, w_depth};
            end
            ST_TEMP: begin
                e_v = w_ok;
                e_res.kind    = dlrd_pkg::K_TEMP;
                e_res.value_a = {{16{w_temp[15]}}, w_temp};
            end
            ST_SET: begin
                if (w_mode == dlrd_pkg::MODE_SCR || w_mode == dlrd_pkg::MODE_CCR) begin
                    e_v = w_ok;
                end
                e_res.kind    = dlrd_pkg::K_SETPOINT;
                e_res.value_a = {16'd0, w_sp};
            end
            ST_GSRCH: begin
                e_res.kind    = dlrd_pkg::K_GAS;
                e_res.index   = 4'(r_si);
                e_res.value_a = {24'd0, w_gasv[15:8]};
                e_res.value_b = {24'd0, w_gasv[7:0]};
                if (r_si < SW'(r_gcnt)) begin
                    e_v = w_ok && w_gmatch;
                end else begin
                    e_v = w_ok;
                    if (r_gcnt >= GCW'(GAS_ENTRIES)) begin
                        e_res.kind    = dlrd_pkg::K_ERROR;
                        e_res.index   = dlrd_pkg::E_GAS_FULL;
                        e_res.value_a = 32'd0;
                        e_res.value_b = 32'd0;
                    end
                end
            end
            ST_DECO: begin
                e_v = w_ok;
                if (w_stop != 16'd0) begin
                    e_res.kind    = dlrd_pkg::K_DECO;
                    e_res.value_a = {16'd0, w_stop};
                    e_res.value_b = {16'd0, w_dtime};
                    e_res.value_c = {16'd0, w_tts};
                end else begin
                    e_res.kind    = dlrd_pkg::K_NDL;
                    e_res.value_a = {16'd0, w_tts};
                end
            end
            ST_CNS: begin
                e_v = w_ok;
                e_res.kind    = dlrd_pkg::K_CNS;
                e_res.value_a = {16'd0, w_cns};
            end
            ST_TANK: begin
                e_v = w_ok && !w_b47[7] && w_b47[6];
                e_res.kind = dlrd_pkg::K_LINKLOST;
            end
            ST_TADD: begin
                e_v = w_ok && w_tnew && (r_cur_ix >= TCW'(TANK_ENTRIES));
                e_res.kind  = dlrd_pkg::K_ERROR;
                e_res.index = dlrd_pkg::E_TANK_FULL;
            end
            ST_TPR: begin
                e_v = w_ok && (r_cur_ix < r_tcnt);
                e_res.kind    = dlrd_pkg::K_PRESSURE;
                e_res.index   = 4'(r_cur_ix);
                e_res.value_a = {23'd0, w_pr};
            end
            ST_BEAR: begin
                e_v = w_ok && w_bemit;
                e_res.kind    = dlrd_pkg::K_BEARING;
                e_res.value_a = {16'd0, w_brg};
            end
            ST_STOT: begin
                e_v = w_ok;
                e_res.kind    = dlrd_pkg::K_TOTALS;
                e_res.value_a = r_lt;
                e_res.value_b = {16'd0, r_maxd};
                e_res.value_c = {16'd0, 8'(r_tcnt), 8'(r_gcnt)};
            end
            ST_SSET: begin
                e_v = w_ok;
                e_res.kind = dlrd_pkg::K_SETTINGS;
                if (r_set_v) begin
                    e_res.index   = 4'd1;
                    e_res.value_a = {24'd0, r_set[31:24]};
                    e_res.value_b = {24'd0, r_set[23:16]};
                    e_res.value_c = {16'd0, r_set[15:0]};
                end
            end
            ST_SGAS: begin
                e_v = w_ok && (r_si < SW'(r_gcnt));
                e_res.kind    = dlrd_pkg::K_GASENT;
                e_res.index   = 4'(r_si);
                e_res.value_a = {24'd0, r_gas[r_si[GIW-1:0]][15:8]};
                e_res.value_b = {24'd0, r_gas[r_si[GIW-1:0]][7:0]};
            end
            ST_STANK: begin
                e_v = w_ok && (r_si < SW'(r_tcnt));
                e_res.kind    = dlrd_pkg::K_TANKENT;
                e_res.index   = 4'(r_si);
                e_res.value_a = {23'd0, r_tank[r_si[TIW-1:0]][17:9]};
                e_res.value_b = {23'd0, r_tank[r_si[TIW-1:0]][8:0]};
                e_res.value_c = {28'd0, r_tank[r_si[TIW-1:0]][21:18]};
            end
            ST_SLOC: begin
                e_v = w_ok;
                e_res.kind    = dlrd_pkg::K_LOCATION;
                e_res.index   = {3'd0, r_loc};
                e_res.value_a = r_loc_w[0];
                e_res.value_b = r_loc_w[1];
                e_res.value_c = r_loc_w[2];
            end
            default: begin
                e_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_rv) begin
            r_g[r_rk] <= r_rz ? 8'd0 : i_buf_rdata;
        end
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_hl     <= 8'd0;
            r_pos    <= 7'd0;
            r_last   <= 1'b0;
            r_k      <= 6'd0;
            r_rv     <= 1'b0;
            r_lt     <= 32'd0;
            r_maxd   <= 16'd0;
            r_prev_v <= 1'b0;
            r_gcnt   <= '0;
            r_tcnt   <= '0;
            r_cur_v  <= 1'b0;
            r_set_v  <= 1'b0;
            r_err    <= 1'b0;
            r_bear   <= 1'b0;
            r_loc    <= 1'b0;
            r_loc_w  <= '{default: 32'd0};
            r_si     <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_v      <= 1'b1;
                r_out        <= r_pend;
                r_out.last   <= (r_st == ST_FLUSH);
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
            if (e_v) begin
                r_pend_v <= 1'b1;
                r_pend   <= e_res;
            end else if (w_push) begin
                r_pend_v <= 1'b0;
            end

            r_rv <= (r_st == ST_GATHER);
            r_rk <= r_k;
            r_rz <= ({1'b0, dlrd_pkg::gaddr(r_k)} >= w_size);

            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_first_of_dive) begin
                            r_hl     <= i_header_size;
                            r_pos    <= 7'd0;
                            r_lt     <= 32'd0;
                            r_maxd   <= 16'd0;
                            r_prev_v <= 1'b0;
                            r_gcnt   <= '0;
                            r_tcnt   <= '0;
                            r_cur_v  <= 1'b0;
                            r_set_v  <= 1'b0;
                            r_err    <= 1'b0;
                            r_bear   <= 1'b0;
                            r_loc    <= 1'b0;
                            r_loc_w  <= '{default: 32'd0};
                        end
                        if (!w_err0) begin
                            if (w_hl0 != 8'd0) begin
                                r_hl <= w_hl0 - 8'd1;
                                if (i_last_of_dive) r_st <= ST_STOT;
                            end else if (w_npos >= w_size) begin
                                r_pos  <= 7'd0;
                                r_k    <= 6'd0;
                                r_last <= i_last_of_dive;
                                r_st   <= ST_GATHER;
                            end else begin
                                r_pos <= w_npos;
                                if (i_last_of_dive) r_st <= ST_STOT;
                            end
                        end
                    end
                end
                ST_GATHER: begin
                    if (r_k == 6'(dlrd_pkg::NGATHER - 1)) begin
                        r_st <= ST_GWAIT;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                ST_GWAIT: begin
                    r_st <= ST_TYPE;
                end
                ST_TYPE: begin
                    if (w_type != 16'd0) begin
                        if (w_type == 16'd1 && !r_loc) begin
                            r_loc_w[0] <= {gb(6'd43), gb(6'd42), gb(6'd41), gb(6'd40)};
                            r_loc_w[1] <= {gb(6'd47), gb(6'd46), gb(6'd45), gb(6'd44)};
                            r_loc_w[2] <= {gb(6'd51), gb(6'd50), gb(6'd49), gb(6'd48)};
                            r_loc      <= 1'b1;
                        end
                        r_st <= ST_FIN;
                    end else begin
                        r_st <= ST_TIME;
                    end
                end
                ST_TIME: begin
                    if (w_ok) begin
                        if (w_terr) begin
                            r_err <= 1'b1;
                            r_st  <= ST_FLUSH;
                        end else begin
                            r_lt <= w_ts;
                            r_st <= ST_DEPTH;
                        end
                    end
                end
                ST_DEPTH: begin
                    if (w_ok) begin
                        if (w_depth > r_maxd) r_maxd <= w_depth;
                        r_st <= ST_TEMP;
                    end
                end
                ST_TEMP: begin
                    if (w_ok) r_st <= ST_SET;
                end
                ST_SET: begin
                    if (w_ok) begin
                        if (!r_set_v) begin
                            r_set_v <= 1'b1;
                            r_set   <= {w_mode, gb(6'd14), gb(6'd15), gb(6'd16)};
                        end
                        r_si <= '0;
                        if (!r_prev_v || r_prev != w_gasv) r_st <= ST_GSRCH;
                        else r_st <= ST_DECO;
                    end
                end
                ST_GSRCH: begin
                    if (w_ok) begin
                        if (r_si < SW'(r_gcnt)) begin
                            if (w_gmatch) begin
                                r_prev_v <= 1'b1;
                                r_prev   <= w_gasv;
                                r_st     <= ST_DECO;
                            end else begin
                                r_si <= r_si + 1'b1;
                            end
                        end else if (r_gcnt >= GCW'(GAS_ENTRIES)) begin
                            r_err <= 1'b1;
                            r_st  <= ST_FLUSH;
                        end else begin
                            r_gas[r_si[GIW-1:0]] <= w_gasv;
                            r_gcnt   <= GCW'(r_si + 1'b1);
                            r_prev_v <= 1'b1;
                            r_prev   <= w_gasv;
                            r_st     <= ST_DECO;
                        end
                    end
                end
                ST_DECO: begin
                    if (w_ok) r_st <= ST_CNS;
                end
                ST_CNS: begin
                    if (w_ok) r_st <= w_long ? ST_TANK : ST_FIN;
                end
                ST_TANK: begin
                    if (w_ok) begin
                        r_si <= '0;
                        if (w_b47[7] || w_b47[6]) begin
                            r_st <= ST_BEAR;
                        end else if (!r_cur_v || r_cur_id != w_id) begin
                            r_st <= ST_TSRCH;
                        end else begin
                            r_st <= ST_TADD;
                        end
                    end
                end
                ST_TSRCH: begin
                    if (r_si < SW'(r_tcnt) && !w_tmatch) begin
                        r_si <= r_si + 1'b1;
                    end else begin
                        r_cur_v  <= 1'b1;
                        r_cur_id <= w_id;
                        r_cur_ix <= TCW'(r_si);
                        r_st     <= ST_TADD;
                    end
                end
                ST_TADD: begin
                    if (w_ok) begin
                        if (w_tnew && r_cur_ix >= TCW'(TANK_ENTRIES)) begin
                            r_err <= 1'b1;
                            r_st  <= ST_FLUSH;
                        end else begin
                            if (w_tnew) begin
                                r_tank[r_cur_ix[TIW-1:0]] <= {w_id, w_pr, w_pr};
                                r_tcnt <= r_cur_ix + 1'b1;
                            end
                            r_st <= ST_TPR;
                        end
                    end
                end
                ST_TPR: begin
                    if (w_ok) begin
                        if (r_cur_ix < r_tcnt) r_tank[r_cur_ix[TIW-1:0]][8:0] <= w_pr;
                        r_st <= ST_BEAR;
                    end
                end
                ST_BEAR: begin
                    if (w_ok) begin
                        if (w_brg != 16'd0) r_bear <= 1'b1;
                        r_st <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_st <= (r_last && !r_err) ? ST_STOT : ST_FLUSH;
                end
                ST_STOT: begin
                    if (w_ok) r_st <= ST_SSET;
                end
                ST_SSET: begin
                    if (w_ok) begin
                        r_si <= '0;
                        r_st <= ST_SGAS;
                    end
                end
                ST_SGAS: begin
                    if (w_ok) begin
                        if (r_si < SW'(r_gcnt)) begin
                            r_si <= r_si + 1'b1;
                        end else begin
                            r_si <= '0;
                            r_st <= ST_STANK;
                        end
                    end
                end
                ST_STANK: begin
                    if (w_ok) begin
                        if (r_si < SW'(r_tcnt)) r_si <= r_si + 1'b1;
                        else r_st <= ST_SLOC;
                    end
                end
                ST_SLOC: begin
                    if (w_ok) r_st <= ST_FLUSH;
                end
                ST_FLUSH: begin
                    if (!r_pend_v || w_out_free) r_st <= ST_IDLE;
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

    `DLRD_ASSERT(a_gas_count, r_gcnt <= GCW'(GAS_ENTRIES), "gas count past table size")
    `DLRD_ASSERT(a_tank_count, r_tcnt <= TCW'(TANK_ENTRIES), "tank count past table size")
    `DLRD_ASSERT(a_idle_drained, (r_st == ST_IDLE) |-> !r_pend_v, "pending result left in idle")
    `DLRD_ASSERT(a_gather_rd, r_rv |-> (r_st == ST_GATHER || r_st == ST_GWAIT), "stray read")

endmodule

FILE: hdl/dive_log_record_decoder_top.sv
// ----------------------------------------------------------------------------
// Dive log record decoder
// Byte-stream dive log framing and record decode to raw result items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one log byte with first/last
//   flags. Output channel (o_valid / i_stall) gives result items; o_last
//   marks the final result caused by one byte.
//   A byte that does not complete a record or end a dive leaves the decoder
//   idle, so o_stall stays low. A completed record reads 38 bytes back from
//   the record buffer (one per cycle, its single read port sets this), then
//   decodes, searching the gas and tank tables one entry at a time. A summary
//   run emits totals, settings, one item per stored gas and tank, and
//   location. Results leave through a pending stage and an output register,
//   so the next byte is taken while the last result still waits on o_valid.
//   Reset (synchronous, active low) clears all per-dive state; config returns
//   to header 50, record 42, no type word, no deco time. A stalled receiver
//   holds the output, and decode stalls once the pending stage is full too.
//   Configuration must be written only while idle; no logic enforces it.
// ----------------------------------------------------------------------------
module dive_log_record_decoder_top #(
    parameter int GAS_ENTRIES  = dlrd_pkg::GAS_ENTRIES_DEF,
    parameter int TANK_ENTRIES = dlrd_pkg::TANK_ENTRIES_DEF,
    parameter int RECORD_BYTES = dlrd_pkg::RECORD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_dive,
    input  logic        i_last_of_dive,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_kind,
    output logic [3:0]  o_index,
    output logic [31:0] o_value_a,
    output logic [31:0] o_value_b,
    output logic [31:0] o_value_c,
    output logic        o_last
);

    logic       r_has_type;
    logic [7:0] r_hdr_size;
    logic [6:0] r_rec_size;
    logic       r_deco_time;

    dlrd_pkg::t_buf_wr           w_wr;
    logic [dlrd_pkg::BUF_AW-1:0] w_raddr;
    logic [7:0]                  w_rdata;
    dlrd_pkg::t_res              w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_type  <= 1'b0;
            r_hdr_size  <= dlrd_pkg::HDR_SIZE_RST;
            r_rec_size  <= dlrd_pkg::REC_SIZE_RST;
            r_deco_time <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dlrd_pkg::CFG_HAS_TYPE:  r_has_type  <= i_cfg_data[0];
                dlrd_pkg::CFG_HDR_SIZE:  r_hdr_size  <= i_cfg_data;
                dlrd_pkg::CFG_REC_SIZE:  r_rec_size  <= i_cfg_data[6:0];
                dlrd_pkg::CFG_DECO_TIME: r_deco_time <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dlrd_rec_buf #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dlrd_core #(
        .GAS_ENTRIES  (GAS_ENTRIES),
        .TANK_ENTRIES (TANK_ENTRIES),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_has_record_type   (r_has_type),
        .i_header_size       (r_hdr_size),
        .i_record_size       (r_rec_size),
        .i_deco_time_present (r_deco_time),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_first_of_dive     (i_first_of_dive),
        .i_last_of_dive      (i_last_of_dive),
        .o_buf_wr            (w_wr),
        .o_buf_raddr         (w_raddr),
        .i_buf_rdata         (w_rdata),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_res               (w_res)
    );

    assign o_kind    = w_res.kind;
    assign o_index   = w_res.index;
    assign o_value_a = w_res.value_a;
    assign o_value_b = w_res.value_b;
    assign o_value_c = w_res.value_c;
    assign o_last    = w_res.last;

endmodule
